// ----- rtl/vfp_pkg.sv -----
// Shared types, constants and helpers of the view frustum plane generator.
package vfp_pkg;

  localparam int SIDE_PLANES = 4;
  localparam int PLANES = 2 * SIDE_PLANES;
  localparam int PW = $clog2(PLANES);
  localparam int SW = $clog2(SIDE_PLANES);
  localparam logic [PW-1:0] LAST_K = PW'(PLANES - 1);
  localparam int QDEPTH = 2;

  localparam logic [27:0] HALF_WIDTH_RESET = 28'd16777216;
  localparam logic [27:0] HALF_HEIGHT_RESET = 28'd9437184;

  localparam logic [1:0] REG_HALF_WIDTH = 2'd0;
  localparam logic [1:0] REG_HALF_HEIGHT = 2'd1;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
  } in_item_t;

  typedef struct packed {
    logic        plane_set;
    logic [1:0]  plane_index;
    logic signed [31:0] normal_a;
    logic signed [31:0] normal_b;
    logic signed [31:0] normal_c;
    logic signed [39:0] offset_d;
    logic        degenerate;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec32_t;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } vec64_t;

  typedef struct packed {
    vec32_t eye;
    vec32_t up;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;
  } job_t;

  function automatic logic signed [31:0] pick32(vec32_t v, logic [1:0] i);
    case (i)
      2'd0: return v.x;
      2'd1: return v.y;
      default: return v.z;
    endcase
  endfunction

  function automatic logic [1:0] next3(logic [1:0] i);
    case (i)
      2'd0: return 2'd1;
      2'd1: return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

endpackage

// ----- rtl/view_frustum_planes_top.sv -----
// Top level of the view frustum side plane generator with its register file.
// Each item passes from the queue to the result bank through the shared normalizer (a 32-step
// square root and a 32-step divide), which it uses eleven times. The eight results then leave
// one per cycle when out_stall is low, while the next item is already computed.
// A two-entry input queue takes new items while earlier ones are in work.
// Synchronous reset empties the queue, idles the sequencer and loads the default extents.
module view_frustum_planes_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [27:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  vfp_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output vfp_pkg::out_item_t out_item
);

  logic [27:0]   half_width;
  logic [27:0]   half_height;
  logic          q_valid;
  logic          q_pop;
  vfp_pkg::job_t job;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= vfp_pkg::HALF_WIDTH_RESET;
      half_height <= vfp_pkg::HALF_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        vfp_pkg::REG_HALF_WIDTH: half_width <= cfg_data;
        vfp_pkg::REG_HALF_HEIGHT: half_height <= cfg_data;
        default: ;
      endcase
    end
  end

  vfp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .job     (job)
  );

  vfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .job        (job),
    .half_width (half_width),
    .half_height(half_height),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

// ----- rtl/vfp_front.sv -----
// Input stage: takes items, forms eye minus target and queues the jobs.
module vfp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  vfp_pkg::in_item_t in_item,
  output logic             q_valid,
  input  logic             q_pop,
  output vfp_pkg::job_t    job
);

  localparam int AW = $clog2(vfp_pkg::QDEPTH);

  vfp_pkg::job_t ent [vfp_pkg::QDEPTH];
  vfp_pkg::job_t job_new;
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW:0]   fill;
  logic          push;

  always_comb begin
    job_new.eye = '{x: in_item.eye_x, y: in_item.eye_y, z: in_item.eye_z};
    job_new.up = '{x: in_item.up_x, y: in_item.up_y, z: in_item.up_z};
    job_new.dx = $signed({in_item.eye_x[31], in_item.eye_x})
               - $signed({in_item.target_x[31], in_item.target_x});
    job_new.dy = $signed({in_item.eye_y[31], in_item.eye_y})
               - $signed({in_item.target_y[31], in_item.target_y});
    job_new.dz = $signed({in_item.eye_z[31], in_item.eye_z})
               - $signed({in_item.target_z[31], in_item.target_z});
  end

  assign in_stall = (fill == (AW+1)'(vfp_pkg::QDEPTH));
  assign push = in_valid && !in_stall;
  assign q_valid = (fill != '0);
  assign job = ent[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wp] <= job_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (q_pop) begin
        rp <= rp + 1'b1;
      end
      fill <= fill + (AW+1)'(push) - (AW+1)'(q_pop);
    end
  end

endmodule

// ----- rtl/vfp_norm.sv -----
// Iterative vector normalizer: scale, sum of squares, square root, divide.
module vfp_norm (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  vfp_pkg::vec64_t vin,
  output logic            done,
  output vfp_pkg::vec32_t vout,
  output logic            zero
);

  typedef enum logic [5:0] {
    N_IDLE  = 6'b000001,
    N_SHIFT = 6'b000010,
    N_SQ    = 6'b000100,
    N_SQRT  = 6'b001000,
    N_DSET  = 6'b010000,
    N_DIV   = 6'b100000
  } nstate_t;

  nstate_t state;
  logic [63:0] m [3];
  logic        neg [3];
  logic [63:0] s;
  logic [63:0] r;
  logic [63:0] sbit;
  logic [30:0] rem [3];
  logic [31:0] low [3];
  logic [4:0]  cnt;

  logic signed [63:0] vi [3];
  logic [63:0] orm;
  logic [29:0] msel;
  logic [59:0] sq;
  logic [63:0] rb;
  logic [30:0] len;
  logic [31:0] tr [3];
  logic [31:0] tdiff [3];
  logic        qb [3];
  logic [31:0] lnx [3];
  logic [60:0] num [3];

  always_comb begin
    vi[0] = vin.x;
    vi[1] = vin.y;
    vi[2] = vin.z;
    orm = m[0] | m[1] | m[2];
    msel = m[cnt[1:0]][29:0];
    sq = msel * msel;
    rb = r + sbit;
    len = r[30:0];
    for (int i = 0; i < 3; i++) begin
      tr[i] = {rem[i], low[i][31]};
      tdiff[i] = tr[i] - {1'b0, len};
      qb[i] = (tr[i] >= {1'b0, len});
      lnx[i] = {low[i][30:0], qb[i]};
      num[i] = {1'b0, m[i][29:0], 30'b0} + {31'b0, r[30:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        N_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              neg[i] <= vi[i][63];
              m[i] <= vi[i][63] ? 64'(-vi[i]) : 64'(vi[i]);
            end
            state <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          if (orm == '0) begin
            vout <= '0;
            zero <= 1'b1;
            done <= 1'b1;
            state <= N_IDLE;
          end else if (|orm[63:38]) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] >> 8;
          end else if (|orm[63:30]) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
          end else if (orm[29:21] == '0) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] << 8;
          end else if (!orm[29]) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] << 1;
          end else begin
            s <= '0;
            cnt <= '0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          s <= s + {4'b0, sq};
          cnt <= cnt + 1'b1;
          if (cnt == 5'd2) begin
            r <= '0;
            sbit <= 64'd1 << 62;
            cnt <= '0;
            state <= N_SQRT;
          end
        end
        N_SQRT: begin
          if (s >= rb) begin
            s <= s - rb;
            r <= (r >> 1) + sbit;
          end else begin
            r <= r >> 1;
          end
          sbit <= sbit >> 2;
          cnt <= cnt + 1'b1;
          if (cnt == 5'd31) begin
            state <= N_DSET;
          end
        end
        N_DSET: begin
          for (int i = 0; i < 3; i++) begin
            rem[i] <= {2'b0, num[i][60:32]};
            low[i] <= num[i][31:0];
          end
          cnt <= '0;
          state <= N_DIV;
        end
        N_DIV: begin
          for (int i = 0; i < 3; i++) begin
            rem[i] <= qb[i] ? tdiff[i][30:0] : tr[i][30:0];
            low[i] <= lnx[i];
          end
          cnt <= cnt + 1'b1;
          if (cnt == 5'd31) begin
            vout.x <= neg[0] ? -lnx[0] : lnx[0];
            vout.y <= neg[1] ? -lnx[1] : lnx[1];
            vout.z <= neg[2] ? -lnx[2] : lnx[2];
            zero <= 1'b0;
            done <= 1'b1;
            state <= N_IDLE;
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/vfp_back.sv -----
// Plane sequencer: basis, corner rays, plane normals, offsets and result bank.
module vfp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_pop,
  input  vfp_pkg::job_t      job,
  input  logic [27:0]        half_width,
  input  logic [27:0]        half_height,
  output logic               out_valid,
  input  logic               out_stall,
  output vfp_pkg::out_item_t out_item
);

  typedef enum logic [12:0] {
    B_IDLE  = 13'b0000000000001,
    B_NZ    = 13'b0000000000010,
    B_CX1   = 13'b0000000000100,
    B_NX    = 13'b0000000001000,
    B_CX2   = 13'b0000000010000,
    B_NY    = 13'b0000000100000,
    B_SCALE = 13'b0000001000000,
    B_CORN  = 13'b0000010000000,
    B_SHRK  = 13'b0000100000000,
    B_CXP   = 13'b0001000000000,
    B_NP    = 13'b0010000000000,
    B_DOT   = 13'b0100000000000,
    B_HAND  = 13'b1000000000000
  } bstate_t;

  localparam int SP = vfp_pkg::SIDE_PLANES;
  localparam int NP = vfp_pkg::PLANES;
  localparam int PW = vfp_pkg::PW;
  localparam int SW = vfp_pkg::SW;

  bstate_t state;
  vfp_pkg::vec32_t eye;
  vfp_pkg::vec32_t up;
  vfp_pkg::vec32_t zu;
  vfp_pkg::vec32_t xu;
  vfp_pkg::vec32_t yu;
  vfp_pkg::vec64_t t;
  logic signed [63:0] acc;
  logic signed [35:0] xs [3];
  logic signed [35:0] ys [3];
  logic signed [37:0] cor [SP][3];
  vfp_pkg::vec32_t nrm [NP];
  logic signed [39:0] dv [NP];
  logic        degen;
  logic [2:0]  c;
  logic [SW-1:0] p;
  logic        pset;
  logic        nstart;

  vfp_pkg::vec32_t onrm [NP];
  logic signed [39:0] odv [NP];
  logic        odeg;
  logic [PW-1:0] ok;
  logic        obusy;

  logic            ndone;
  logic            nzero;
  vfp_pkg::vec32_t nout;

  vfp_pkg::vec32_t va;
  vfp_pkg::vec32_t vb;
  vfp_pkg::vec32_t c0v;
  vfp_pkg::vec32_t c1v;
  logic [1:0]  j;
  logic [1:0]  ia;
  logic [1:0]  ib;
  logic signed [31:0] ma;
  logic signed [31:0] mb;
  logic signed [63:0] prod;
  logic signed [63:0] rsum;
  logic signed [63:0] dsum;
  logic signed [36:0] xv [3];
  logic signed [36:0] yv [3];
  logic signed [37:0] zz [3];
  logic signed [37:0] cn [SP][3];
  logic [37:0] am;
  logic [37:0] orc [SP];
  logic        need [SP];
  logic        anyneed;
  logic signed [37:0] sh [SP][3];
  logic [PW-1:0] k;

  vfp_norm u_norm (
    .clk  (clk),
    .rst  (rst),
    .start(nstart),
    .vin  (t),
    .done (ndone),
    .vout (nout),
    .zero (nzero)
  );

  assign k = {pset, p};
  assign q_pop = (state == B_IDLE) && q_valid;

  always_comb begin
    c0v = '{x: cor[0][0][31:0], y: cor[0][1][31:0], z: cor[0][2][31:0]};
    c1v = '{x: cor[1][0][31:0], y: cor[1][1][31:0], z: cor[1][2][31:0]};
    case (state)
      B_CX1: begin
        va = up;
        vb = zu;
      end
      B_CX2: begin
        va = xu;
        vb = zu;
      end
      default: begin
        va = c0v;
        vb = c1v;
      end
    endcase
    j = c[2:1];
    if (c[0]) begin
      ia = vfp_pkg::next3(vfp_pkg::next3(j));
      ib = vfp_pkg::next3(j);
    end else begin
      ia = vfp_pkg::next3(j);
      ib = vfp_pkg::next3(vfp_pkg::next3(j));
    end
    case (state)
      B_SCALE: begin
        if (c < 3'd3) begin
          ma = vfp_pkg::pick32(xu, c[1:0]);
          mb = $signed({4'b0, half_width});
        end else begin
          ma = vfp_pkg::pick32(yu, 2'(c - 3'd3));
          mb = $signed({4'b0, half_height});
        end
      end
      B_DOT: begin
        ma = vfp_pkg::pick32(eye, c[1:0]);
        mb = vfp_pkg::pick32(nout, c[1:0]);
      end
      default: begin
        ma = vfp_pkg::pick32(va, ia);
        mb = vfp_pkg::pick32(vb, ib);
      end
    endcase
    prod = ma * mb;
    rsum = prod + 64'sd8388608 - $signed({63'b0, prod[63]});
    dsum = acc + 64'sd536870912 - $signed({63'b0, acc[63]});

    for (int i = 0; i < 3; i++) begin
      xv[i] = pset ? {xs[i][35], xs[i]} : {xs[i], 1'b0};
      yv[i] = pset ? {ys[i][35], ys[i]} : {ys[i], 1'b0};
      zz[i] = 38'(vfp_pkg::pick32(zu, 2'(i)));
      cn[0][i] = -38'(xv[i]) - 38'(yv[i]) + zz[i];
      cn[1][i] = 38'(xv[i]) - 38'(yv[i]) + zz[i];
      cn[2][i] = 38'(xv[i]) + 38'(yv[i]) + zz[i];
      cn[3][i] = -38'(xv[i]) + 38'(yv[i]) + zz[i];
    end

    anyneed = 1'b0;
    for (int q = 0; q < SP; q++) begin
      orc[q] = '0;
      for (int i = 0; i < 3; i++) begin
        am = cor[q][i][37] ? 38'(-cor[q][i]) : 38'(cor[q][i]);
        orc[q] = orc[q] | am;
        sh[q][i] = (cor[q][i] + $signed({37'b0, cor[q][i][37]})) >>> 1;
      end
      need[q] = |orc[q][37:30];
      anyneed = anyneed | need[q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      nstart <= 1'b0;
      obusy <= 1'b0;
      ok <= '0;
      c <= '0;
      p <= '0;
      pset <= 1'b0;
    end else begin
      nstart <= 1'b0;
      if (obusy && !out_stall) begin
        ok <= ok + 1'b1;
        if (ok == vfp_pkg::LAST_K) begin
          obusy <= 1'b0;
        end
      end
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            eye <= job.eye;
            up <= job.up;
            t.x <= 64'(job.dx);
            t.y <= 64'(job.dy);
            t.z <= 64'(job.dz);
            degen <= 1'b0;
            nstart <= 1'b1;
            state <= B_NZ;
          end
        end
        B_NZ, B_NX, B_NY: begin
          if (ndone) begin
            degen <= degen | nzero;
            c <= '0;
            case (state)
              B_NZ: begin
                zu <= nout;
                state <= B_CX1;
              end
              B_NX: begin
                xu <= nout;
                state <= B_CX2;
              end
              default: begin
                yu <= nout;
                state <= B_SCALE;
              end
            endcase
          end
        end
        B_CX1, B_CX2, B_CXP: begin
          if (!c[0]) begin
            acc <= prod;
          end else begin
            case (j)
              2'd0: t.x <= acc - prod;
              2'd1: t.y <= acc - prod;
              default: t.z <= acc - prod;
            endcase
          end
          c <= c + 1'b1;
          if (c == 3'd5) begin
            nstart <= 1'b1;
            case (state)
              B_CX1: state <= B_NX;
              B_CX2: state <= B_NY;
              default: begin
                for (int q = 0; q < SP; q++) begin
                  for (int i = 0; i < 3; i++) begin
                    cor[q][i] <= cor[(q + 1) % SP][i];
                  end
                end
                state <= B_NP;
              end
            endcase
          end
        end
        B_SCALE: begin
          if (c < 3'd3) begin
            xs[c[1:0]] <= rsum[59:24];
          end else begin
            ys[2'(c - 3'd3)] <= rsum[59:24];
          end
          c <= c + 1'b1;
          if (c == 3'd5) begin
            pset <= 1'b0;
            state <= B_CORN;
          end
        end
        B_CORN: begin
          for (int q = 0; q < SP; q++) begin
            for (int i = 0; i < 3; i++) begin
              cor[q][i] <= cn[q][i];
            end
          end
          p <= '0;
          state <= B_SHRK;
        end
        B_SHRK: begin
          for (int q = 0; q < SP; q++) begin
            if (need[q]) begin
              for (int i = 0; i < 3; i++) begin
                cor[q][i] <= sh[q][i];
              end
            end
          end
          if (!anyneed) begin
            c <= '0;
            state <= B_CXP;
          end
        end
        B_NP: begin
          if (ndone) begin
            degen <= degen | nzero;
            nrm[k] <= nout;
            acc <= '0;
            c <= '0;
            state <= B_DOT;
          end
        end
        B_DOT: begin
          if (c == 3'd3) begin
            dv[k] <= 40'sd1 - $signed({{6{dsum[63]}}, dsum[63:30]});
            c <= '0;
            p <= p + 1'b1;
            if (p == SW'(SP - 1)) begin
              if (pset) begin
                state <= B_HAND;
              end else begin
                pset <= 1'b1;
                state <= B_CORN;
              end
            end else begin
              state <= B_CXP;
            end
          end else begin
            acc <= acc + prod;
            c <= c + 1'b1;
          end
        end
        B_HAND: begin
          if (!obusy) begin
            for (int q = 0; q < NP; q++) begin
              onrm[q] <= nrm[q];
              odv[q] <= dv[q];
            end
            odeg <= degen;
            ok <= '0;
            obusy <= 1'b1;
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_comb begin
    out_valid = obusy;
    out_item.plane_set = ok[PW-1];
    out_item.plane_index = ok[PW-2:0];
    out_item.normal_a = onrm[ok].x;
    out_item.normal_b = onrm[ok].y;
    out_item.normal_c = onrm[ok].z;
    out_item.offset_d = odv[ok];
    out_item.degenerate = odeg;
    out_item.last = (ok == vfp_pkg::LAST_K);
  end

`ifndef SYNTHESIS
  a_bank_release: assert property (@(posedge clk) disable iff (rst)
    $fell(obusy) |-> $past(ok) == vfp_pkg::LAST_K)
    else $error("result bank released before its last item");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (obusy && !out_stall && ok == vfp_pkg::LAST_K) |=> !obusy)
    else $error("result bank still busy after its last item");

  a_norm_wait: assert property (@(posedge clk) disable iff (rst)
    ndone |-> (state == B_NZ || state == B_NX || state == B_NY || state == B_NP))
    else $error("normalizer finished outside a wait step");
`endif

endmodule

// ----- dv/view_frustum_planes_checker.sv -----
// Checker for the view frustum plane generator: predicts the eight planes of each item and compares.
module view_frustum_planes_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [27:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  vfp_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  vfp_pkg::out_item_t out_item,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint v3_t [3];

  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned ONE_Q29 = 64'd1 << 29;

  logic [27:0] half_w;
  logic [27:0] half_h;
  vfp_pkg::out_item_t planes_due[$];

  function automatic longint unsigned umag(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint signed_mag(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint round_off(longint v, int k);
    longint unsigned m;
    m = (umag(v) + (64'd1 << (k - 1))) >> k;
    return signed_mag(m, v < 0);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned peak(v3_t v);
    longint unsigned m;
    m = 0;
    for (int i = 0; i < 3; i++) if (umag(v[i]) > m) m = umag(v[i]);
    return m;
  endfunction

  function automatic v3_t shrink(v3_t v);
    while (peak(v) >= ONE_Q30)
      for (int i = 0; i < 3; i++) v[i] = signed_mag(umag(v[i]) >> 1, v[i] < 0);
    return v;
  endfunction

  function automatic v3_t cross3(v3_t a, v3_t b);
    v3_t r;
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
    return r;
  endfunction

  function automatic v3_t unit_q30(v3_t v, output bit zero);
    longint unsigned s, len;
    v3_t r;
    r = '{0, 0, 0};
    zero = (peak(v) == 0);
    if (zero) return r;
    v = shrink(v);
    while (peak(v) < ONE_Q29)
      for (int i = 0; i < 3; i++) v[i] = signed_mag(umag(v[i]) << 1, v[i] < 0);
    s = 0;
    for (int i = 0; i < 3; i++) s = s + umag(v[i]) * umag(v[i]);
    len = int_sqrt(s);
    for (int i = 0; i < 3; i++)
      r[i] = signed_mag(((umag(v[i]) << 30) + len / 2) / len, v[i] < 0);
    return r;
  endfunction

  function automatic void frustum_planes(vfp_pkg::in_item_t it);
    v3_t eye, tgt, up, zu, xu, yu, n;
    v3_t cor [4];
    vfp_pkg::out_item_t res [vfp_pkg::PLANES];
    bit dg, zr;
    longint xv, yv, mult, dot;
    int k;
    eye = '{longint'(it.eye_x), longint'(it.eye_y), longint'(it.eye_z)};
    tgt = '{longint'(it.target_x), longint'(it.target_y), longint'(it.target_z)};
    up = '{longint'(it.up_x), longint'(it.up_y), longint'(it.up_z)};
    zu = unit_q30('{eye[0] - tgt[0], eye[1] - tgt[1], eye[2] - tgt[2]}, dg);
    xu = unit_q30(cross3(up, zu), zr);
    dg |= zr;
    yu = unit_q30(cross3(xu, zu), zr);
    dg |= zr;
    for (int set = 0; set < 2; set++) begin
      mult = (set == 0) ? 2 : 1;
      for (int i = 0; i < 3; i++) begin
        xv = round_off(xu[i] * longint'(half_w), 24) * mult;
        yv = round_off(yu[i] * longint'(half_h), 24) * mult;
        cor[0][i] = -xv - yv + zu[i];
        cor[1][i] = xv - yv + zu[i];
        cor[2][i] = xv + yv + zu[i];
        cor[3][i] = -xv + yv + zu[i];
      end
      for (int p = 0; p < vfp_pkg::SIDE_PLANES; p++) cor[p] = shrink(cor[p]);
      for (int p = 0; p < vfp_pkg::SIDE_PLANES; p++) begin
        k = set * vfp_pkg::SIDE_PLANES + p;
        n = unit_q30(cross3(cor[p], cor[(p + 1) % vfp_pkg::SIDE_PLANES]), zr);
        dg |= zr;
        dot = eye[0] * n[0] + eye[1] * n[1] + eye[2] * n[2];
        res[k].plane_set = set[0];
        res[k].plane_index = p[1:0];
        res[k].normal_a = n[0][31:0];
        res[k].normal_b = n[1][31:0];
        res[k].normal_c = n[2][31:0];
        res[k].offset_d = 40'(1 - round_off(dot, 30));
        res[k].last = (k == vfp_pkg::PLANES - 1);
      end
    end
    for (int j = 0; j < vfp_pkg::PLANES; j++) begin
      res[j].degenerate = dg;
      planes_due.push_back(res[j]);
    end
  endfunction

  task automatic mismatch(string field, longint e, longint a);
    $display("%0t: %s expected %0d got %0d", $time, field, e, a);
    errors++;
  endtask

  assign pending = planes_due.size();

  always @(posedge clk) begin
    vfp_pkg::out_item_t e;
    if (rst) begin
      half_w <= vfp_pkg::HALF_WIDTH_RESET;
      half_h <= vfp_pkg::HALF_HEIGHT_RESET;
      planes_due.delete();
      errors <= 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == vfp_pkg::REG_HALF_WIDTH) half_w <= cfg_data;
        else if (cfg_index == vfp_pkg::REG_HALF_HEIGHT) half_h <= cfg_data;
      end
      if (in_valid && !in_stall) frustum_planes(in_item);
      if (out_valid && !out_stall) begin
        if (planes_due.size() == 0) begin
          $display("%0t: unexpected plane, got %p", $time, out_item);
          errors++;
        end else begin
          e = planes_due.pop_front();
          if (out_item.plane_set !== e.plane_set)
            mismatch("plane_set", e.plane_set, out_item.plane_set);
          if (out_item.plane_index !== e.plane_index)
            mismatch("plane_index", e.plane_index, out_item.plane_index);
          if (out_item.normal_a !== e.normal_a)
            mismatch("normal_a", e.normal_a, out_item.normal_a);
          if (out_item.normal_b !== e.normal_b)
            mismatch("normal_b", e.normal_b, out_item.normal_b);
          if (out_item.normal_c !== e.normal_c)
            mismatch("normal_c", e.normal_c, out_item.normal_c);
          if (out_item.offset_d !== e.offset_d)
            mismatch("offset_d", e.offset_d, out_item.offset_d);
          if (out_item.degenerate !== e.degenerate)
            mismatch("degenerate", e.degenerate, out_item.degenerate);
          if (out_item.last !== e.last)
            mismatch("last", e.last, out_item.last);
        end
      end
    end
  end

endmodule

// ----- dv/view_frustum_planes_top_tb.sv -----
// Testbench top for the view frustum plane generator: stimulus, stalls, configuration and verdict.
module view_frustum_planes_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [31:0] MAX_POS = 32'h7fffffff;
  localparam logic [31:0] MAX_NEG = 32'h80000000;

  logic clk, rst, cfg_write, in_valid, in_stall, out_valid, out_stall;
  logic [1:0] cfg_index;
  logic [27:0] cfg_data;
  vfp_pkg::in_item_t in_item;
  vfp_pkg::out_item_t out_item;
  int errors, pending, send_idle, recv_idle, hold_len, cycles;

  view_frustum_planes_top i_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  view_frustum_planes_checker i_checker (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // The receiver either holds off for a counted stretch or stalls at random.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else if (hold_len > 0) begin
      out_stall <= 1;
      hold_len = hold_len - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  function automatic vfp_pkg::in_item_t mk(logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz);
    vfp_pkg::in_item_t it;
    it = {ex, ey, ez, tx, ty, tz, ux, uy, uz};
    return it;
  endfunction

  function automatic logic [31:0] coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(4194304)) - 2097152);
      2: return 32'($signed($urandom_range(65536)) - 32768);
      3: return ($urandom_range(1)) ? MAX_POS : MAX_NEG;
      4: return 32'($signed($urandom_range(2)) - 1);
      default: return 32'($signed($urandom_range(268435456)) - 134217728);
    endcase
  endfunction

  function automatic vfp_pkg::in_item_t rand_item();
    vfp_pkg::in_item_t it;
    it = {coord(), coord(), coord(), coord(), coord(), coord(), coord(), coord(), coord()};
    // Occasionally make the eye coincide with the target, the up hint parallel to the view, or the up hint zero.
    case ($urandom_range(15))
      0: {it.target_x, it.target_y, it.target_z} = {it.eye_x, it.eye_y, it.eye_z};
      1: {it.up_x, it.up_y, it.up_z} = {it.eye_x - it.target_x, it.eye_y - it.target_y,
                                        it.eye_z - it.target_z};
      2: {it.up_x, it.up_y, it.up_z} = '0;
      default: ;
    endcase
    return it;
  endfunction

  task automatic send(vfp_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_extents(logic [27:0] hw, logic [27:0] hh);
    cfg_write <= 1;
    cfg_index <= vfp_pkg::REG_HALF_WIDTH;
    cfg_data <= hw;
    @(posedge clk);
    cfg_index <= vfp_pkg::REG_HALF_HEIGHT;
    cfg_data <= hh;
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_data <= 28'($urandom);
    @(posedge clk);
    cfg_write <= 0;
    @(posedge clk);
  endtask

  task automatic random_phase(int n, int si, int ri);
    send_idle = si;
    recv_idle = ri;
    repeat (n) send(rand_item());
    drain();
  endtask

  initial begin
    cycles = 0;
    hold_len = 0;
    send_idle = 0;
    recv_idle = 0;
    rst <= 1;
    cfg_write <= 0;
    cfg_index <= vfp_pkg::REG_HALF_WIDTH;
    cfg_data <= '0;
    in_valid <= 0;
    in_item <= '0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(0, 0, 32'h50000, 0, 0, 0, 0, 32'h10000, 0));
    send(mk(32'h30000, 32'h20000, 32'h10000, 32'h30000, 32'h20000, 32'h10000, 0, 32'h10000, 0));
    send(mk(0, 0, 32'h50000, 0, 0, 0, 0, 0, 32'h10000));
    send(mk(0, 0, 32'h50000, 0, 0, 0, 0, 0, 0));
    send(mk(MAX_POS, MAX_POS, MAX_POS, MAX_NEG, MAX_NEG, MAX_NEG, MAX_POS, MAX_NEG, MAX_POS));
    send(mk(MAX_NEG, MAX_NEG, MAX_NEG, MAX_POS, MAX_POS, MAX_POS, MAX_NEG, MAX_POS, MAX_NEG));
    send(mk(MAX_POS, MAX_POS, MAX_POS, MAX_POS, MAX_POS, 0, MAX_POS, MAX_POS, MAX_POS));
    send(mk(MAX_NEG, 0, MAX_POS, 0, MAX_NEG, 0, 1, 0, 0));
    send(mk(32'hffffffff, 0, 0, 0, 0, 0, 0, 1, 0));
    send(mk(0, 1, 0, 0, 0, 0, 32'hffffffff, 0, 0));
    send(mk(32'h12345678, 32'hedcba987, 32'h0f0f0f0f, 32'hf0f0f0f0, 32'h55555555,
            32'haaaaaaaa, 32'h33333333, 32'hcccccccc, 32'h00010000));
    drain();

    random_phase(110, 0, 0);
    set_extents(28'hfffffff, 28'h0000000);
    random_phase(110, 50, 0);
    set_extents(28'h0000000, 28'hfffffff);
    hold_len = 4000;
    random_phase(110, 0, 50);
    set_extents(28'($urandom), 28'($urandom));
    random_phase(60, 33, 33);
    set_extents(28'h1000000, 28'h0900000);
    random_phase(50, 33, 33);

    repeat (1100) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
